// File: sv/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;
  localparam int unsigned FREE_SLOTS_DEF = 1024;
  localparam logic [31:0] PAGE_MASK = 32'h0000_0fff;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_LOST    = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Per-cell flags produced from the broadcast request.
  typedef struct packed {
    logic valid;   // cell holds a region
    logic fit;     // length >= size
    logic above;   // start > addr
    logic end_eq;  // start + length == addr
    logic beg_eq;  // addr + size == start
  } cell_flags_t;

  // Edit command broadcast to every cell.
  typedef enum logic [5:0] {
    CMD_NONE    = 6'b000001,
    CMD_CARVE   = 6'b000010,  // target: start += size, len -= size
    CMD_GROW    = 6'b000100,  // target: len += size (+ next len if merge2)
    CMD_PREPEND = 6'b001000,  // target: start = addr, len += size
    CMD_SHDOWN  = 6'b010000,  // cells >= target take from upper neighbor
    CMD_INSERT  = 6'b100000   // cells > target take from lower, target = new
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        merge2;
    logic [31:0] addr;
    logic [31:0] size;
  } cell_cmd_t;
endpackage
`default_nettype wire

// File: sv/ffa_cell.sv
// One slot of the sorted free-region chain: holds start and length,
// compares against the broadcast request and shifts with its neighbors.
// Depends on ffa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffa_cell
  import ffa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        is_target,
  input  wire logic        above_target,
  input  wire logic        dn_valid,
  input  wire logic [31:0] dn_start,
  input  wire logic [31:0] dn_len,
  input  wire logic        up_valid,
  input  wire logic [31:0] up_start,
  input  wire logic [31:0] up_len,
  input  wire cell_cmd_t   cmd,
  output logic             valid,
  output logic [31:0]      start,
  output logic [31:0]      len,
  output cell_flags_t      flags
);
  logic [31:0] grow_len;

  assign grow_len = len + cmd.size + (cmd.merge2 ? up_len : 32'd0);

  always_comb begin
    flags.valid  = valid;
    flags.fit    = len >= cmd.size;
    flags.above  = start > cmd.addr;
    flags.end_eq = (start + len) == cmd.addr;
    flags.beg_eq = (cmd.addr + cmd.size) == start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (cmd.cmd)
        CMD_CARVE: begin
          if (is_target) begin
            start <= start + cmd.size;
            len   <= len - cmd.size;
          end
        end
        CMD_GROW: begin
          if (is_target) len <= grow_len;
        end
        CMD_PREPEND: begin
          if (is_target) begin
            start <= cmd.addr;
            len   <= len + cmd.size;
          end
        end
        CMD_SHDOWN: begin
          if (is_target || above_target) begin
            valid <= up_valid;
            start <= up_start;
            len   <= up_len;
          end
        end
        CMD_INSERT: begin
          if (is_target) begin
            valid <= 1'b1;
            start <= cmd.addr;
            len   <= cmd.size;
          end else if (above_target) begin
            valid <= dn_valid;
            start <= dn_start;
            len   <= dn_len;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/ffa_chain.sv
// Row of ffa_cell slots with per-cell flags gathered into vectors.
// Depends on ffa_pkg and ffa_cell.
`timescale 1ns / 1ps
`default_nettype none
module ffa_chain
  import ffa_pkg::*;
#(
  parameter int unsigned FREE_SLOTS = FREE_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_cmd_t             cmd,
  input  wire logic [FREE_SLOTS-1:0] target,
  input  wire logic [FREE_SLOTS-1:0] above,
  input  wire logic [FREE_SLOTS-1:0] pick,
  output logic [FREE_SLOTS-1:0]      v_valid,
  output logic [FREE_SLOTS-1:0]      v_fit,
  output logic [FREE_SLOTS-1:0]      v_above,
  output logic [FREE_SLOTS-1:0]      v_end_eq,
  output logic [FREE_SLOTS-1:0]      v_beg_eq,
  output logic [31:0]                pick_start,
  output logic [31:0]                pick_len
);
  logic [FREE_SLOTS-1:0] valid;
  logic [31:0]           start [FREE_SLOTS];
  logic [31:0]           len   [FREE_SLOTS];
  cell_flags_t           flags [FREE_SLOTS];

  for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
    logic        dv, uv;
    logic [31:0] ds, dl, us, ul;
    if (g == 0) begin : g_lo
      assign dv = 1'b0;
      assign ds = 32'd0;
      assign dl = 32'd0;
    end else begin : g_lo
      assign dv = valid[g-1];
      assign ds = start[g-1];
      assign dl = len[g-1];
    end
    if (g == FREE_SLOTS - 1) begin : g_hi
      assign uv = 1'b0;
      assign us = 32'd0;
      assign ul = 32'd0;
    end else begin : g_hi
      assign uv = valid[g+1];
      assign us = start[g+1];
      assign ul = len[g+1];
    end
    ffa_cell u_cell (
      .clk, .rst,
      .is_target   (target[g]),
      .above_target(above[g]),
      .dn_valid(dv), .dn_start(ds), .dn_len(dl),
      .up_valid(uv), .up_start(us), .up_len(ul),
      .cmd,
      .valid(valid[g]), .start(start[g]), .len(len[g]),
      .flags(flags[g])
    );
    assign v_valid[g]  = flags[g].valid;
    assign v_fit[g]    = flags[g].fit;
    assign v_above[g]  = flags[g].above;
    assign v_end_eq[g] = flags[g].end_eq;
    assign v_beg_eq[g] = flags[g].beg_eq;
  end

  // one-hot AND-OR select of a single cell's contents
  always_comb begin
    pick_start = '0;
    pick_len   = '0;
    for (int k = 0; k < FREE_SLOTS; k++) begin
      pick_start = pick_start | (start[k] & {32{pick[k]}});
      pick_len   = pick_len | (len[k] & {32{pick[k]}});
    end
  end
endmodule
`default_nettype wire

// File: sv/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list allocator: request sequencer,
// counters and result register. Depends on ffa_pkg and ffa_chain.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: accept, cell compare and priority pick (S_PICK),
// one broadcast edit (shift, carve, merge or insert) across the cell row
// (S_EDIT), then the result is held until taken (S_OUT). A free that
// merges with both neighbors needs a second edit to close the gap. The
// next request is accepted in the cycle the result is taken, so a new
// request cannot start before the previous result is taken. Regions live
// in a chain of FREE_SLOTS cells kept sorted by start address; cells
// shift one place per edit.
module first_fit_free_list_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned FREE_SLOTS = FREE_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] region_addr,
  input  wire logic [31:0] region_size,
  input  wire logic        page_round,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      alloc_addr,
  output logic [1:0]       status,
  output logic [31:0]      free_total,
  output logic [10:0]      entries_in_use,
  output logic [10:0]      peak_entries,
  output logic [30:0]      lost_count,
  output logic [31:0]      lost_bytes
);
  localparam int unsigned CW = $clog2(FREE_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PICK  = 4'b0010,
    S_EDIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;
  op_t         op;
  logic [31:0] size;
  cell_cmd_t   cmd;
  logic [FREE_SLOTS-1:0] target, above;
  logic [FREE_SLOTS-1:0] v_valid, v_fit, v_above, v_end_eq, v_beg_eq;
  logic [FREE_SLOTS-1:0] fit_m, pos_m, first_fit, first_pos, below_pos;
  logic [CW-1:0] count, peak;
  logic [30:0]   lost_c;
  logic [31:0]   lost_b, fsum;
  logic [31:0]   grant;
  status_t       st;
  logic [31:0]   cell_start_sel;
  logic [31:0]   cell_len_sel;

  ffa_chain #(.FREE_SLOTS(FREE_SLOTS)) u_chain (
    .clk, .rst, .cmd, .target, .above,
    .pick(first_fit),
    .v_valid, .v_fit, .v_above, .v_end_eq, .v_beg_eq,
    .pick_start(cell_start_sel), .pick_len(cell_len_sel)
  );

  // first set bit as a one-hot mask
  assign fit_m     = v_valid & v_fit;
  assign pos_m     = v_valid & v_above;
  assign first_fit = fit_m & (~fit_m + 1'b1);
  assign first_pos = pos_m & (~pos_m + 1'b1);
  // index i is first_pos, or count when no start lies above; cell i-1 is below
  assign below_pos = (pos_m == '0) ? (v_valid ^ (v_valid >> 1)) : (first_pos >> 1);

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign out_valid = (state == S_OUT);

  logic [FREE_SLOTS-1:0] ins_pos;
  assign ins_pos = (pos_m == '0) ? ~v_valid & (v_valid << 1 | {{(FREE_SLOTS-1){1'b0}}, 1'b1})
                                 : first_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      peak   <= '0;
      lost_c <= '0;
      lost_b <= '0;
      fsum   <= '0;
      cmd.cmd <= CMD_NONE;
      target <= '0;
      above  <= '0;
    end else begin
      cmd.cmd <= CMD_NONE;
      unique case (state)
        S_IDLE, S_OUT: begin
          if (in_valid && in_ready) begin
            op       <= op_t'(operation);
            size     <= page_round ? (region_size + PAGE_MASK) & ~PAGE_MASK : region_size;
            cmd.addr <= region_addr;
            cmd.size <= page_round ? (region_size + PAGE_MASK) & ~PAGE_MASK : region_size;
            cmd.merge2 <= 1'b0;
            state    <= S_PICK;
          end else if (state == S_OUT && out_ready) begin
            state <= S_IDLE;
          end
        end
        S_PICK: begin
          state <= S_EDIT;
          grant <= 32'd0;
          st    <= ST_OK;
          if (op == OP_ALLOC) begin
            if (fit_m == '0) begin
              st <= ST_NO_FIT;
            end else begin
              grant  <= cell_start_sel;
              fsum   <= fsum - size;
              target <= first_fit;
              above  <= ~((first_fit << 1) - 1'b1) & ~first_fit;
              if (cell_len_sel == size) begin
                cmd.cmd <= CMD_SHDOWN;
                count   <= count - 1'b1;
              end else begin
                cmd.cmd <= CMD_CARVE;
              end
            end
          end else if ((below_pos & v_end_eq) != '0) begin
            fsum    <= fsum + size;
            target  <= below_pos;
            cmd.cmd <= CMD_GROW;
            if ((first_pos & v_beg_eq) != '0) begin
              cmd.merge2 <= 1'b1;
              count <= count - 1'b1;
            end
          end else if ((first_pos & v_beg_eq) != '0) begin
            fsum    <= fsum + size;
            target  <= first_pos;
            cmd.cmd <= CMD_PREPEND;
          end else if (count < CW'(FREE_SLOTS)) begin
            fsum    <= fsum + size;
            target  <= ins_pos;
            above   <= ~((ins_pos << 1) - 1'b1) & ~ins_pos;
            cmd.cmd <= CMD_INSERT;
            count   <= count + 1'b1;
            if (count + 1'b1 > peak) peak <= count + 1'b1;
          end else begin
            st     <= ST_LOST;
            lost_c <= lost_c + 1'b1;
            lost_b <= lost_b + size;
          end
        end
        S_EDIT: begin
          // after a merge of both sides, close the gap above the target
          if (cmd.merge2) begin
            cmd.cmd    <= CMD_SHDOWN;
            cmd.merge2 <= 1'b0;
            target     <= target << 1;
            above      <= ~((target << 2) - 1'b1);
          end else begin
            state <= S_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign alloc_addr     = grant;
  assign status         = st;
  assign free_total     = fsum;
  assign entries_in_use = 11'(count);
  assign peak_entries   = 11'(peak);
  assign lost_count     = lost_c;
  assign lost_bytes     = lost_b;
endmodule
`default_nettype wire

// File: sv/ffa_checker.sv
// Port-level checks for the allocator; bound to the top level.
// Depends on ffa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffa_checker
  import ffa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] alloc_addr,
  input wire logic [1:0]  status,
  input wire logic [10:0] entries_in_use,
  input wire logic [10:0] peak_entries
);
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(alloc_addr)) else $error("result changed");
  a_peak: assert property (@(posedge clk) disable iff (rst)
    entries_in_use <= peak_entries) else $error("peak below count");
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> alloc_addr == 32'd0) else $error("addr on failure");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");
  // a new request is only taken when no result is left waiting
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready) else $error("result overrun");
endmodule

bind first_fit_free_list_allocator ffa_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .alloc_addr, .status, .entries_in_use, .peak_entries
);
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for first_fit_free_list_allocator.
// Depends on ffa_pkg and the allocator RTL; a scoreboard class tracks the free table.
`timescale 1ns / 1ps
module testbench;
  import ffa_pkg::*;

  localparam int SLOTS = 1024;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  st;
    logic [31:0] total;
    logic [10:0] entries;
    logic [10:0] peak;
    logic [30:0] lost_n;
    logic [31:0] lost_b;
  } alloc_result_t;

  class free_table_scoreboard;
    logic [31:0] starts[SLOTS];
    logic [31:0] lens[SLOTS];
    int          count;
    int          peak;
    logic [30:0] lost_n;
    logic [31:0] lost_b;
    logic [31:0] total;
    alloc_result_t pending[$];
    int          errors;

    function new();
      count = 0; peak = 0; lost_n = '0; lost_b = '0; total = '0; errors = 0;
    endfunction

    function void remove_at(int pos);
      count--;
      for (int k = pos; k < count; k++) begin
        starts[k] = starts[k + 1];
        lens[k] = lens[k + 1];
      end
    endfunction

    function void note_request(op_t op, logic [31:0] addr, logic [31:0] size, logic round);
      alloc_result_t r;
      int i;
      bit done;
      if (round) size = (size + PAGE_MASK) & ~PAGE_MASK;
      r.addr = '0;
      r.st = ST_OK;
      done = 0;
      if (op == OP_ALLOC) begin
        r.st = ST_NO_FIT;
        for (int k = 0; k < count && !done; k++) begin
          if (lens[k] >= size) begin
            r.addr = starts[k];
            r.st = ST_OK;
            starts[k] += size;
            lens[k] -= size;
            total -= size;
            if (lens[k] == 0) remove_at(k);
            done = 1;
          end
        end
      end else begin
        i = count;
        for (int k = 0; k < count; k++) begin
          if (starts[k] > addr) begin
            i = k;
            break;
          end
        end
        if (i > 0 && starts[i - 1] + lens[i - 1] == addr) begin
          lens[i - 1] += size;
          total += size;
          if (i < count && addr + size == starts[i]) begin
            lens[i - 1] += lens[i];
            remove_at(i);
          end
        end else if (i < count && addr + size == starts[i]) begin
          starts[i] = addr;
          lens[i] += size;
          total += size;
        end else if (count < SLOTS) begin
          for (int k = count; k > i; k--) begin
            starts[k] = starts[k - 1];
            lens[k] = lens[k - 1];
          end
          count++;
          if (count > peak) peak = count;
          starts[i] = addr;
          lens[i] = size;
          total += size;
        end else begin
          lost_n += 1;
          lost_b += size;
          r.st = ST_LOST;
        end
      end
      r.total = total;
      r.entries = count[10:0];
      r.peak = peak[10:0];
      r.lost_n = lost_n;
      r.lost_b = lost_b;
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: addr %h status %0d", got.addr, got.st);
        return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp addr %h st %0d total %h ent %0d peak %0d lost %0d/%h; ",
                    "got addr %h st %0d total %h ent %0d peak %0d lost %0d/%h"},
                   exp_r.addr, exp_r.st, exp_r.total, exp_r.entries, exp_r.peak,
                   exp_r.lost_n, exp_r.lost_b, got.addr, got.st, got.total, got.entries,
                   got.peak, got.lost_n, got.lost_b);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        operation = 0;
  logic [31:0] region_addr = '0;
  logic [31:0] region_size = '0;
  logic        page_round = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] alloc_addr;
  logic [1:0]  status;
  logic [31:0] free_total;
  logic [10:0] entries_in_use;
  logic [10:0] peak_entries;
  logic [30:0] lost_count;
  logic [31:0] lost_bytes;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  free_table_scoreboard sb = new();

  always #5 clk = ~clk;

  first_fit_free_list_allocator DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .region_addr(region_addr), .region_size(region_size),
    .page_round(page_round), .out_valid(out_valid), .out_ready(out_ready),
    .alloc_addr(alloc_addr), .status(status), .free_total(free_total),
    .entries_in_use(entries_in_use), .peak_entries(peak_entries),
    .lost_count(lost_count), .lost_bytes(lost_bytes)
  );

  // Result side: check on handshake, pick next ready at random.
  always @(posedge clk) begin
    alloc_result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.addr = alloc_addr; got.st = status; got.total = free_total;
        got.entries = entries_in_use; got.peak = peak_entries;
        got.lost_n = lost_count; got.lost_b = lost_bytes;
        sb.check_result(got);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("first_fit_free_list_allocator test failed");
        $finish;
      end
    end
  end

  task automatic send_request(op_t op, logic [31:0] addr, logic [31:0] size, logic round);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    region_addr <= addr;
    region_size <= size;
    page_round <= round;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, addr, size, round);
  endtask

  task automatic random_mix(int n);
    logic [31:0] a, s;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 5) begin
        // mostly grid-aligned frees so neighbors merge
        if ($urandom_range(9) == 0) begin
          a = $urandom(); s = $urandom();
        end else begin
          a = $urandom_range(63) * 256; s = $urandom_range(4) * 256;
        end
        send_request(OP_FREE, a, s, $urandom_range(3) == 0);
      end else begin
        s = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1024);
        send_request(OP_ALLOC, $urandom(), s, $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed corners
    send_request(OP_ALLOC, 32'h0, 32'h10, 0);            // empty table: no fit
    send_request(OP_FREE, 32'h0, 32'h0, 0);              // zero-length region
    send_request(OP_ALLOC, 32'hffff_ffff, 32'h0, 0);     // zero-size grant at address 0
    send_request(OP_FREE, 32'h1000, 32'h1000, 0);
    send_request(OP_FREE, 32'h3000, 32'h1000, 0);
    send_request(OP_FREE, 32'h2000, 32'h1000, 0);        // merges both sides
    send_request(OP_FREE, 32'h5000, 32'h100, 0);
    send_request(OP_FREE, 32'h4f00, 32'h100, 0);         // merges above
    send_request(OP_FREE, 32'h5100, 32'h1, 1);           // rounded, merges below
    send_request(OP_ALLOC, 32'h0, 32'h1, 1);
    send_request(OP_ALLOC, 32'h0, 32'hffff_ffff, 0);     // no fit
    send_request(OP_ALLOC, 32'h0, 32'hffff_ffff, 1);     // rounds to zero
    send_request(OP_FREE, 32'hffff_0000, 32'h1_0000, 0); // end wraps to zero
    send_request(OP_FREE, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_request(OP_FREE, 32'h2000, 32'h800, 0);         // overlapping free
    send_request(OP_ALLOC, 32'h0, 32'h1000, 0);
    send_request(OP_ALLOC, 32'h0, 32'h3000, 0);
    send_request(OP_FREE, 32'haaaa_5555, 32'h5555_aaaa, 1);
    send_request(OP_ALLOC, 32'h0, 32'h100, 0);
    send_request(OP_ALLOC, 32'h0, 32'h0, 1);

    random_mix(60);
    send_idle_pct = 75;
    random_mix(60);
    send_idle_pct = 0; recv_stall_pct = 75;
    random_mix(60);
    send_idle_pct = 8; recv_stall_pct = 8;
    random_mix(60);
    send_idle_pct = 0; recv_stall_pct = 0;
    // fill the table with isolated regions until frees get dropped
    for (int k = 0; k < 1060; k++)
      send_request(OP_FREE, 32'h8000_0000 + k * 16, $urandom_range(1, 8), 0);
    random_mix(40);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("first_fit_free_list_allocator test passed");
    end else begin
      $display("first_fit_free_list_allocator test failed");
    end
    $finish;
  end
endmodule
